// ===== hdl/lkvt_pkg.sv =====
package lkvt_pkg;

    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_PEEK   = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // broadcast to every cell; append/write/shift only pulse on commit
    typedef struct packed {
        logic compare;
        logic append;
        logic write;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== hdl/lkvt_cell.sv =====
module lkvt_cell
    import lkvt_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64,
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [CW-1:0]         i_count,
    input  logic [KEY_BITS-1:0]   i_nb_key,
    input  logic [VALUE_BITS-1:0] i_nb_value,
    input  logic                  i_prefix,
    input  logic [VALUE_BITS-1:0] i_or,
    output logic                  o_prefix,
    output logic [VALUE_BITS-1:0] o_or,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);

    localparam logic [CW-1:0] MY_POS = CW'(INDEX);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_match;

    // prefix: a match sits at this cell or somewhere before it
    assign o_prefix = i_prefix | r_match;
    assign o_or     = i_or | (r_match ? r_value : '0);
    assign o_key    = r_key;
    assign o_value  = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.compare) begin
            r_match <= (MY_POS < i_count) && (r_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && o_prefix) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
        end else if (i_ctl.write && r_match) begin
            r_value <= i_value;
        end else if (i_ctl.append && (MY_POS == i_count)) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

endmodule

// ===== hdl/linear_key_value_table.sv =====
// Key-value table, up to CAPACITY entries kept in insertion order.
// Input channel (i_in_valid / o_in_ready) carries one command beat:
// action, key and write_value. Output channel (o_out_valid / i_out_ready)
// returns one result beat per command: value, was_present, status and
// entry_total.
// Each entry lives in one cell of a chain. In S_CMP a command compares
// the key against every cell in parallel; in S_UPD it resolves the hit
// along the chain and commits the append, write or shift-down.
// A new command is accepted while the table is idle, or in the same cycle
// in which the previous command commits, so commands follow one another
// through the compare-then-commit pair of the cell chain.
// The result register lets the next command be accepted and compared
// while the previous result waits; the commit of that next command holds
// until the result register frees up, so a stalled receiver stalls the
// table without losing beats.
// Reset (synchronous, active low) empties the table at once; the slot
// contents themselves are not cleared.
module linear_key_value_table
    import lkvt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_key,
    input  logic [63:0]        i_write_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [63:0]        o_value,
    output logic               o_was_present,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entry_total
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    t_state                r_state, n_state;
    logic [2:0]            r_action;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wv;
    logic [CW-1:0]         r_count, n_count;

    logic                  r_out_valid;
    logic [63:0]           r_value, n_value;
    logic                  r_was_present;
    logic [1:0]            r_status, n_status;
    logic [6:0]            r_total;

    logic                  accept, commit, hit;
    logic [VALUE_BITS-1:0] hit_value, bcast_value, res_value;
    logic signed [63:0]    key_ext;
    t_cell_ctl             ctl;
    logic                  do_append, do_write, do_shift;

    logic [KEY_BITS-1:0]   key_arr   [CAPACITY+1];
    logic [VALUE_BITS-1:0] value_arr [CAPACITY+1];
    logic                  prefix_arr[CAPACITY+1];
    logic [VALUE_BITS-1:0] or_arr    [CAPACITY+1];

    assign key_ext     = 64'(i_key);
    assign commit      = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE) || commit;
    assign accept      = i_in_valid && o_in_ready;

    assign hit         = prefix_arr[CAPACITY];
    assign hit_value   = or_arr[CAPACITY];
    assign bcast_value = (r_action == ACT_WRITE) ? r_wv : '0;

    assign ctl.compare = (r_state == S_CMP);
    assign ctl.append  = commit && do_append;
    assign ctl.write   = commit && do_write;
    assign ctl.shift   = commit && do_shift;

    assign key_arr[CAPACITY]   = '0;
    assign value_arr[CAPACITY] = '0;
    assign prefix_arr[0]       = 1'b0;
    assign or_arr[0]           = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lkvt_cell #(
            .INDEX      (g),
            .CAPACITY   (CAPACITY),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_key      (r_key),
            .i_value    (bcast_value),
            .i_count    (r_count),
            .i_nb_key   (key_arr[g+1]),
            .i_nb_value (value_arr[g+1]),
            .i_prefix   (prefix_arr[g]),
            .i_or       (or_arr[g]),
            .o_prefix   (prefix_arr[g+1]),
            .o_or       (or_arr[g+1]),
            .o_key      (key_arr[g]),
            .o_value    (value_arr[g])
        );
    end

    always_comb begin
        do_append = 1'b0;
        do_write  = 1'b0;
        do_shift  = 1'b0;
        n_count   = r_count;
        n_status  = ST_OK;
        res_value = '0;
        unique case (r_action) inside
            ACT_READ, ACT_WRITE: begin
                if (hit) begin
                    do_write  = (r_action == ACT_WRITE);
                    res_value = (r_action == ACT_WRITE) ? r_wv : hit_value;
                end else if (r_count == FULL_COUNT) begin
                    n_status = ST_FULL;
                end else begin
                    do_append = 1'b1;
                    n_count   = r_count + 1'b1;
                    res_value = bcast_value;
                end
            end
            ACT_REMOVE: begin
                if (hit) begin
                    do_shift = 1'b1;
                    n_count  = r_count - 1'b1;
                end else begin
                    n_status = ST_MISSING;
                end
            end
            ACT_CLEAR: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = '0;
                end
            end
            default: begin
                res_value = hit ? hit_value : '0;
            end
        endcase
        n_value = 64'(res_value);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (commit) n_state = accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_key    <= key_ext[KEY_BITS-1:0];
            r_wv     <= i_write_value[VALUE_BITS-1:0];
        end
        if (commit) begin
            r_value       <= n_value;
            r_was_present <= hit;
            r_status      <= n_status;
            r_total       <= 7'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_was_present = r_was_present;
    assign o_status      = r_status;
    assign o_entry_total = r_total;

endmodule

// ===== hdl/lkvt_checker.sv =====
module lkvt_checker
    import lkvt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_value,
    input logic        o_was_present,
    input logic [1:0]  o_status,
    input logic [6:0]  o_entry_total
);

    // a result beat that is not taken stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // count never beyond capacity (only checkable while it fits in 7 bits)
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 127) || (o_entry_total <= 7'(CAPACITY)))
        else $error("entry total beyond capacity");

    // a full-table refusal only happens for an absent key, with zero value and a full total
    a_full_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |->
            !o_was_present && (o_value == 64'd0) && (o_entry_total == 7'(CAPACITY)))
        else $error("bad full-table result");

    // missing-key status only when the key was not held, with zero value
    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_MISSING) |-> !o_was_present && (o_value == 64'd0))
        else $error("missing status with key present");

endmodule

bind linear_key_value_table lkvt_checker #(.CAPACITY(CAPACITY)) u_lkvt_checker (.*);
